/* hw/rtl/icsp_pkg.sv */
// ----------------------------------------------------------------------------
// icsp_pkg
// Shared types and constants for the serial programming bit sequencer.
// ----------------------------------------------------------------------------
package icsp_pkg;

  // Frame geometry
  localparam int COMMAND_BITS = 4;
  localparam int PAYLOAD_BITS = 16;
  localparam int FRAME_BITS   = COMMAND_BITS + PAYLOAD_BITS;
  localparam int FRAME_IDX_W  = $clog2(FRAME_BITS);
  localparam int KEY_BITS     = 32;
  localparam int BYTE_BITS    = 8;
  localparam int TICK_W       = 7;
  localparam int HOLD_W       = 16;
  localparam int OP_W         = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LEAVE = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT  = 3'd4;

  // Word kinds on the cmd field
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Command sent by a table read
  localparam logic [COMMAND_BITS-1:0] READ_COMMAND = COMMAND_BITS'(9);

  // Tick boundaries
  localparam logic [TICK_W-1:0] KEY_PRE_TICKS  = TICK_W'(3);
  localparam logic [TICK_W-1:0] KEY_RESET_TICK = TICK_W'(1);
  localparam logic [TICK_W-1:0] KEY_TAIL_TICK  = TICK_W'(3 + 2 * KEY_BITS);
  localparam logic [TICK_W-1:0] FRAME_TICKS    = TICK_W'(2 * FRAME_BITS);
  localparam logic [TICK_W-1:0] WAIT_TICKS     = TICK_W'(8);
  localparam logic [TICK_W-2:0] CAPTURE_BIT    = (TICK_W-1)'(FRAME_BITS - BYTE_BITS);

  // Sequencer state
  typedef struct packed {
    logic [OP_W-1:0]         active_op;
    logic [KEY_BITS-1:0]     shift_word;
    logic [TICK_W-1:0]       tick_index;
    logic [HOLD_W-1:0]       hold_count;
    logic [BYTE_BITS-1:0]    capture_byte;
    logic [COMMAND_BITS-1:0] cmd_latch;
    logic                    running;
  } seq_state_t;

  // One pin frame
  typedef struct packed {
    logic                 clock_pin;
    logic                 data_pin;
    logic                 reset_pin;
    logic                 busy_res;
    logic [BYTE_BITS-1:0] read_byte;
    logic                 read_valid;
  } pin_frame_t;

endpackage

/* hw/rtl/icsp_step.sv */
// ----------------------------------------------------------------------------
// icsp_step
// Next-state and pin-frame logic for one accepted word.
// ----------------------------------------------------------------------------
module icsp_step (
  input  icsp_pkg::seq_state_t               state_i,
  input  logic                               cmd_i,
  input  logic [icsp_pkg::OP_W-1:0]          op_kind_i,
  input  logic [3:0]                         command_code_i,
  input  logic [31:0]                        value_i,
  input  logic [15:0]                        hold_ticks_i,
  input  logic                               data_in_i,
  output icsp_pkg::seq_state_t               state_o,
  output icsp_pkg::pin_frame_t               frame_o,
  output logic                               frame_valid_o
);

  logic [icsp_pkg::TICK_W-1:0]       tick;
  logic [icsp_pkg::TICK_W-2:0]       bit_idx;
  logic [icsp_pkg::TICK_W-1:0]       key_k;
  logic                              is_read;
  logic [icsp_pkg::COMMAND_BITS-1:0] cmdv;
  logic [icsp_pkg::PAYLOAD_BITS-1:0] payload;
  logic [icsp_pkg::FRAME_BITS-1:0]   frame_bits;

  assign tick    = state_i.tick_index;
  assign bit_idx = tick[icsp_pkg::TICK_W-1:1];
  assign key_k   = tick - icsp_pkg::KEY_PRE_TICKS;
  assign is_read = (state_i.active_op == icsp_pkg::OP_READ);

  // Command then payload, LSB first; read sends a fixed command and zeros
  assign cmdv       = is_read ? icsp_pkg::READ_COMMAND : state_i.cmd_latch;
  assign payload    = is_read ? '0 : state_i.shift_word[icsp_pkg::PAYLOAD_BITS-1:0];
  assign frame_bits = {payload, cmdv};

  always_comb begin
    state_o       = state_i;
    frame_o       = '0;
    frame_valid_o = 1'b0;

    if (cmd_i == icsp_pkg::CMD_LOAD) begin
      // Load: unknown op codes leave everything untouched
      if (op_kind_i <= icsp_pkg::OP_WAIT) begin
        state_o.active_op    = op_kind_i;
        state_o.tick_index   = '0;
        state_o.running      = 1'b1;
        state_o.capture_byte = '0;
        state_o.hold_count   = hold_ticks_i;
        state_o.cmd_latch    = command_code_i[icsp_pkg::COMMAND_BITS-1:0];
        state_o.shift_word   = value_i;
      end
    end else begin
      frame_valid_o = 1'b1;
      if (!state_i.running) begin
        // Idle: reset stays high unless the last op was leave
        frame_o.reset_pin = (state_i.active_op != icsp_pkg::OP_LEAVE);
      end else begin
        case (state_i.active_op)
          icsp_pkg::OP_LEAVE: begin
            state_o.running = 1'b0;
          end
          icsp_pkg::OP_KEY: begin
            if (tick < icsp_pkg::KEY_PRE_TICKS) begin
              frame_o.reset_pin  = (tick == icsp_pkg::KEY_RESET_TICK);
              state_o.tick_index = tick + 1'b1;
            end else if (tick < icsp_pkg::KEY_TAIL_TICK) begin
              // Key MSB first, shift after the clock-high tick
              frame_o.data_pin   = state_i.shift_word[icsp_pkg::KEY_BITS-1];
              frame_o.clock_pin  = key_k[0];
              if (key_k[0]) begin
                state_o.shift_word = {state_i.shift_word[icsp_pkg::KEY_BITS-2:0], 1'b0};
              end
              state_o.tick_index = tick + 1'b1;
            end else if (tick == icsp_pkg::KEY_TAIL_TICK) begin
              state_o.tick_index = tick + 1'b1;
            end else begin
              frame_o.reset_pin = 1'b1;
              state_o.running   = 1'b0;
            end
          end
          icsp_pkg::OP_WRITE, icsp_pkg::OP_READ: begin
            frame_o.reset_pin = 1'b1;
            if (tick < icsp_pkg::FRAME_TICKS) begin
              // Two ticks per bit: clock high, then clock low
              frame_o.data_pin  = frame_bits[bit_idx[icsp_pkg::FRAME_IDX_W-1:0]];
              frame_o.clock_pin = ~tick[0];
              if (is_read && tick[0] && (bit_idx >= icsp_pkg::CAPTURE_BIT)) begin
                state_o.capture_byte = {data_in_i, state_i.capture_byte[7:1]};
              end
              state_o.tick_index = tick + 1'b1;
            end else begin
              if (is_read) begin
                frame_o.read_valid = 1'b1;
                frame_o.read_byte  = state_i.capture_byte;
              end
              state_o.running = 1'b0;
            end
          end
          default: begin
            // Wait: the clock pin toggles, then is held high while hold_count counts down
            frame_o.reset_pin = 1'b1;
            if (tick < icsp_pkg::WAIT_TICKS) begin
              frame_o.clock_pin  = tick[0];
              state_o.tick_index = tick + 1'b1;
            end else if (state_i.hold_count != '0) begin
              frame_o.clock_pin  = 1'b1;
              state_o.hold_count = state_i.hold_count - 1'b1;
            end else begin
              state_o.running = 1'b0;
            end
          end
        endcase
      end
      frame_o.busy_res = state_o.running;
    end
  end

endmodule

/* hw/rtl/icsp_bit_sequencer_top.sv */
// ----------------------------------------------------------------------------
// icsp_bit_sequencer_top
// Serial programming master: drives clock, data and reset pins one tick at a time.
// ----------------------------------------------------------------------------
// A load word (cmd 0) starts an operation and returns nothing; each tick word
// (cmd 1) returns one pin frame. The block takes one word per clock cycle unless
// the output stalls, and the frame is registered and appears on the output in
// the cycle after its tick word is accepted; the rate is set by the single output
// register, which frees itself in the same cycle its frame is taken, so a stalled
// output stops input only while that register is full and not being read.
module icsp_bit_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [2:0]  op_kind_i,
  input  logic [3:0]  command_code_i,
  input  logic [31:0] value_i,
  input  logic [15:0] hold_ticks_i,
  input  logic        data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        clock_pin_o,
  output logic        data_pin_o,
  output logic        reset_pin_o,
  output logic        busy_res_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o
);

  icsp_pkg::seq_state_t state_q, state_d;
  icsp_pkg::pin_frame_t frame_d, frame_q;
  logic                 frame_valid;
  logic                 out_valid_q;
  logic                 in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // Step logic
  icsp_step u_step (
    .state_i       (state_q),
    .cmd_i         (cmd_i),
    .op_kind_i     (op_kind_i),
    .command_code_i(command_code_i),
    .value_i       (value_i),
    .hold_ticks_i  (hold_ticks_i),
    .data_in_i     (data_in_i),
    .state_o       (state_d),
    .frame_o       (frame_d),
    .frame_valid_o (frame_valid)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && frame_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output frame
  always_ff @(posedge clk_i) begin
    if (in_fire && frame_valid) begin
      frame_q <= frame_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign clock_pin_o  = frame_q.clock_pin;
  assign data_pin_o   = frame_q.data_pin;
  assign reset_pin_o  = frame_q.reset_pin;
  assign busy_res_o   = frame_q.busy_res;
  assign read_byte_o  = frame_q.read_byte;
  assign read_valid_o = frame_q.read_valid;

endmodule

/* hw/rtl/icsp_checker.sv */
// ----------------------------------------------------------------------------
// icsp_checker
// Port-level checks on the bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module icsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        clock_pin_o,
  input logic        data_pin_o,
  input logic        reset_pin_o,
  input logic        busy_res_o,
  input logic [7:0]  read_byte_o,
  input logic        read_valid_o
);

  logic in_fire;
  assign in_fire = in_valid_i & in_ready_o;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(clock_pin_o)
      && $stable(data_pin_o) && $stable(reset_pin_o) && $stable(busy_res_o)
      && $stable(read_byte_o) && $stable(read_valid_o))
    else $error("stalled output word changed");

  // Every tick word gives a frame on the next cycle
  a_tick_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cmd_i |=> out_valid_o)
    else $error("tick word produced no frame");

  // A load word never produces a frame
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !cmd_i && !out_valid_o |=> !out_valid_o)
    else $error("load word produced a frame");

  // Read completion ends the operation with reset high and clock low
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> !busy_res_o && reset_pin_o && !clock_pin_o)
    else $error("read completion frame malformed");

  // Byte is zero outside read completion
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_byte_o == 8'd0)
    else $error("read byte set without read completion");

endmodule

bind icsp_bit_sequencer_top icsp_checker u_icsp_checker (.*);
